// ===== rtl/assert_macros.svh =====
// assertion helpers, sampled on clock and held off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a property that must hold at every edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// when the trigger holds, the consequence holds in the same cycle
`define ASSERT_IMPLY(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) else $error(msg);

`endif

// ===== rtl/mma_pkg.sv =====
`default_nettype none

package mma_pkg;

   localparam int WINDOW   = 10;
   localparam int CHANNELS = 8;

   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 32;

   // running sum holds WINDOW samples plus sign headroom
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW) + 2;
   localparam int POS_W    = $clog2(WINDOW + 1);
   localparam int CH_IDX_W = (CHANNELS > 1) ?
                             (($clog2(CHANNELS) < CH_W) ? $clog2(CHANNELS) : CH_W) : 1;
   localparam int CH_CMP_W = CH_W + 2;

   localparam int RING_DEPTH = CHANNELS * WINDOW;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   // divider retires DIV_BITS quotient bits per cycle
   localparam int DIV_BITS  = 8;
   localparam int DIV_ITER  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_PAD_W = DIV_ITER * DIV_BITS;
   localparam int DIV_CNT_W = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

   localparam int QDEPTH = 2;
   localparam int QAW    = 1;
   localparam int QCNT_W = 2;

   localparam logic signed [SAMPLE_W-1:0] AVG_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] AVG_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef struct packed {
      logic                       bad;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SUM,
      ST_DIV,
      ST_TRACK,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/mma_ram.sv =====
`default_nettype none

module mma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mma_front.sv =====
`default_nettype none

module mma_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [mma_pkg::CH_W-1:0]            req_channel,
   input  wire logic signed [mma_pkg::SAMPLE_W-1:0] req_sample,
   output      mma_pkg::item_type                   item,
   output      logic                                item_valid,
   input  wire logic                                item_pop
);

   mma_pkg::item_type               q_ff [mma_pkg::QDEPTH];
   logic [mma_pkg::QAW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [mma_pkg::QAW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [mma_pkg::QCNT_W-1:0]      count_ff, count_in;
   mma_pkg::item_type               new_item;
   logic                            push;

   // channels past the configured count are marked and skip the averaging in the back end
   always_comb begin
      new_item.bad     = (mma_pkg::CH_CMP_W'(req_channel) >=
                          mma_pkg::CH_CMP_W'(mma_pkg::CHANNELS));
      new_item.channel = req_channel;
      new_item.sample  = req_sample;
   end

   assign req_ready  = (count_ff != mma_pkg::QCNT_W'(mma_pkg::QDEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + mma_pkg::QCNT_W'(push) - mma_pkg::QCNT_W'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mma_div.sv =====
`default_nettype none

module mma_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [mma_pkg::SUM_W-1:0]    dividend,
   input  wire logic [mma_pkg::POS_W-1:0]           divisor,
   output      logic                                done,
   output      logic signed [mma_pkg::SAMPLE_W-1:0] quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mma_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [mma_pkg::DIV_PAD_W-1:0]     shift_ff, shift_in;
   logic [mma_pkg::POS_W:0]           rem_ff, rem_in;
   logic                              neg_ff, neg_in;
   logic [mma_pkg::POS_W-1:0]         dvs_ff, dvs_in;
   logic [mma_pkg::SAMPLE_W-1:0]      q_low;

   always_comb begin
      logic [mma_pkg::POS_W:0]       rem_t;
      logic [mma_pkg::DIV_PAD_W-1:0] sh_t;
      logic [mma_pkg::SUM_W-1:0]     mag;

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      dvs_in   = dvs_ff;
      rem_t    = rem_ff;
      sh_t     = shift_ff;
      mag      = dividend[mma_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;

      if (start) begin
         // work on the magnitude so the quotient truncates toward zero
         busy_in  = 1'b1;
         cnt_in   = mma_pkg::DIV_CNT_W'(mma_pkg::DIV_ITER - 1);
         shift_in = mma_pkg::DIV_PAD_W'(mag);
         rem_in   = '0;
         neg_in   = dividend[mma_pkg::SUM_W-1];
         dvs_in   = divisor;
      end else if (busy_ff) begin
         for (int i = 0; i < mma_pkg::DIV_BITS; i++) begin
            rem_t = {rem_t[mma_pkg::POS_W-1:0], sh_t[mma_pkg::DIV_PAD_W-1]};
            sh_t  = {sh_t[mma_pkg::DIV_PAD_W-2:0], 1'b0};
            if (rem_t >= {1'b0, dvs_ff}) begin
               rem_t   = rem_t - {1'b0, dvs_ff};
               sh_t[0] = 1'b1;
            end
         end
         shift_in = sh_t;
         rem_in   = rem_t;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      dvs_ff   <= dvs_in;
   end

   // the mean always fits in a sample, so the low bits carry the result
   assign q_low    = shift_ff[mma_pkg::SAMPLE_W-1:0];
   assign quotient = neg_ff ? (~q_low + 1'b1) : q_low;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== rtl/mma_back.sv =====
`default_nettype none

module mma_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire mma_pkg::item_type                   item,
   input  wire logic                                item_valid,
   output      logic                                item_pop,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [mma_pkg::CH_W-1:0]            channel_out,
   output      logic signed [mma_pkg::SAMPLE_W-1:0] average,
   output      logic signed [mma_pkg::SAMPLE_W-1:0] lowest_average,
   output      logic signed [mma_pkg::SAMPLE_W-1:0] highest_average,
   output      logic                                window_full
);

   mma_pkg::back_state_type state_ff, state_in;

   mma_pkg::item_type                   item_ff, item_in;
   logic [mma_pkg::POS_W-1:0]           pos_ff, pos_in;
   logic                                wrap_ff, wrap_in;
   logic [mma_pkg::RING_AW-1:0]         addr_ff, addr_in;
   logic signed [mma_pkg::SAMPLE_W-1:0] avg_ff, avg_in;

   // per-channel state
   logic [mma_pkg::POS_W-1:0]           wpos_ff    [mma_pkg::CHANNELS];
   logic                                wrapped_ff [mma_pkg::CHANNELS];
   logic signed [mma_pkg::SUM_W-1:0]    sum_ff     [mma_pkg::CHANNELS];
   logic signed [mma_pkg::SAMPLE_W-1:0] min_ff     [mma_pkg::CHANNELS];
   logic signed [mma_pkg::SAMPLE_W-1:0] max_ff     [mma_pkg::CHANNELS];

   logic                                chan_wr, mm_wr;
   logic [mma_pkg::POS_W-1:0]           wpos_in;
   logic signed [mma_pkg::SUM_W-1:0]    sum_in;
   logic signed [mma_pkg::SAMPLE_W-1:0] min_in, max_in;

   logic [mma_pkg::CH_W-1:0]            out_ch_ff, out_ch_in;
   logic signed [mma_pkg::SAMPLE_W-1:0] out_avg_ff, out_avg_in;
   logic signed [mma_pkg::SAMPLE_W-1:0] out_lo_ff, out_lo_in;
   logic signed [mma_pkg::SAMPLE_W-1:0] out_hi_ff, out_hi_in;
   logic                                out_full_ff, out_full_in;

   logic [mma_pkg::CH_IDX_W-1:0]        idx;
   logic [mma_pkg::POS_W-1:0]           cur_wpos, pos_eff;
   logic                                at_end;
   logic [mma_pkg::RING_AW-1:0]         ring_addr;

   logic                                ram_wr, ram_rd;
   logic [mma_pkg::SAMPLE_W-1:0]        ram_rd_data;
   logic signed [mma_pkg::SUM_W-1:0]    old_ext, new_ext;

   logic                                div_start, div_done;
   logic [mma_pkg::POS_W-1:0]           div_divisor;
   logic signed [mma_pkg::SAMPLE_W-1:0] div_quotient;

   assign idx       = item_ff.channel[mma_pkg::CH_IDX_W-1:0];
   assign cur_wpos  = wpos_ff[idx];
   assign at_end    = (cur_wpos == mma_pkg::POS_W'(mma_pkg::WINDOW));
   assign pos_eff   = at_end ? '0 : cur_wpos;
   assign ring_addr = mma_pkg::RING_AW'(idx * mma_pkg::RING_AW'(mma_pkg::WINDOW))
                      + mma_pkg::RING_AW'(pos_eff);

   // the overwritten entry only leaves the sum once the ring has wrapped
   assign old_ext = wrap_ff ?
                    {{(mma_pkg::SUM_W-mma_pkg::SAMPLE_W){ram_rd_data[mma_pkg::SAMPLE_W-1]}},
                     ram_rd_data} : '0;
   assign new_ext = {{(mma_pkg::SUM_W-mma_pkg::SAMPLE_W){item_ff.sample[mma_pkg::SAMPLE_W-1]}},
                     item_ff.sample};

   mma_ram #(
      .WIDTH (mma_pkg::SAMPLE_W),
      .DEPTH (mma_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr_ff),
      .wr_data (item_ff.sample),
      .rd_en   (ram_rd),
      .rd_addr (ring_addr),
      .rd_data (ram_rd_data)
   );

   mma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      pos_in      = pos_ff;
      wrap_in     = wrap_ff;
      addr_in     = addr_ff;
      avg_in      = avg_ff;
      item_pop    = 1'b0;
      ram_rd      = 1'b0;
      ram_wr      = 1'b0;
      chan_wr     = 1'b0;
      mm_wr       = 1'b0;
      div_start   = 1'b0;
      wpos_in     = pos_ff + 1'b1;
      sum_in      = sum_ff[idx] - old_ext + new_ext;
      div_divisor = wrap_ff ? mma_pkg::POS_W'(mma_pkg::WINDOW) : wpos_in;
      min_in      = (avg_ff < min_ff[idx]) ? avg_ff : min_ff[idx];
      max_in      = (avg_ff > max_ff[idx]) ? avg_ff : max_ff[idx];
      out_ch_in   = out_ch_ff;
      out_avg_in  = out_avg_ff;
      out_lo_in   = out_lo_ff;
      out_hi_in   = out_hi_ff;
      out_full_in = out_full_ff;
      rsp_valid   = 1'b0;

      unique case (state_ff)
         mma_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               if (item.bad) begin
                  out_ch_in   = item.channel;
                  out_avg_in  = '0;
                  out_lo_in   = mma_pkg::AVG_POS_MAX;
                  out_hi_in   = mma_pkg::AVG_NEG_MAX;
                  out_full_in = 1'b0;
                  state_in    = mma_pkg::ST_OUT;
               end else begin
                  state_in = mma_pkg::ST_LOOKUP;
               end
            end
         end
         mma_pkg::ST_LOOKUP: begin
            ram_rd   = 1'b1;
            pos_in   = pos_eff;
            wrap_in  = wrapped_ff[idx] || at_end;
            addr_in  = ring_addr;
            state_in = mma_pkg::ST_SUM;
         end
         mma_pkg::ST_SUM: begin
            ram_wr    = 1'b1;
            chan_wr   = 1'b1;
            div_start = 1'b1;
            state_in  = mma_pkg::ST_DIV;
         end
         mma_pkg::ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quotient;
               state_in = mma_pkg::ST_TRACK;
            end
         end
         mma_pkg::ST_TRACK: begin
            mm_wr       = 1'b1;
            out_ch_in   = item_ff.channel;
            out_avg_in  = avg_ff;
            out_lo_in   = min_in;
            out_hi_in   = max_in;
            out_full_in = wrap_ff;
            state_in    = mma_pkg::ST_OUT;
         end
         mma_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = mma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pos_ff      <= pos_in;
      wrap_ff     <= wrap_in;
      addr_ff     <= addr_in;
      avg_ff      <= avg_in;
      out_ch_ff   <= out_ch_in;
      out_avg_ff  <= out_avg_in;
      out_lo_ff   <= out_lo_in;
      out_hi_ff   <= out_hi_in;
      out_full_ff <= out_full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
            wpos_ff[c]    <= '0;
            wrapped_ff[c] <= 1'b0;
            sum_ff[c]     <= '0;
            min_ff[c]     <= mma_pkg::AVG_POS_MAX;
            max_ff[c]     <= mma_pkg::AVG_NEG_MAX;
         end
      end else begin
         if (chan_wr) begin
            wpos_ff[idx]    <= wpos_in;
            wrapped_ff[idx] <= wrap_ff;
            sum_ff[idx]     <= sum_in;
         end
         if (mm_wr) begin
            min_ff[idx] <= min_in;
            max_ff[idx] <= max_in;
         end
      end
   end

   assign channel_out     = out_ch_ff;
   assign average         = out_avg_ff;
   assign lowest_average  = out_lo_ff;
   assign highest_average = out_hi_ff;
   assign window_full     = out_full_ff;

endmodule

`default_nettype wire

// ===== rtl/multichannel_moving_average_minmax.sv =====
// Per-channel moving average of signed Q16.16 samples, with the running
// minimum and maximum of each channel's averages.
// req channel: tdata carries the sample, tuser the channel number. One result
// beat comes back on rsp for every request beat, in order.
// rsp tdata: average, lowest average, highest average; rsp tuser: channel and
// the window-full flag.
// A two-entry queue takes request beats while the back end works, so the
// sender sees tready high until two beats wait behind the one in progress.
// Each item passes through the back end with rsp_tready high in these steps:
// pop, ring read, sum update, the divider (five 8-bit quotient steps plus
// its done strobe), min/max update and the output. A channel past the channel
// count goes from the pop straight to the output and returns the reset
// constants without touching state.
// While rsp_tready is low the result holds, the back end waits and the queue
// fills, after which req_tready drops.
// Reset clears the queue, the write positions, sums and wrap flags and sets
// the min/max trackers to their extremes; the sample ring needs no clearing.
`default_nettype none

`include "assert_macros.svh"

module multichannel_moving_average_minmax (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [mma_pkg::SAMPLE_W-1:0]  req_tdata,   // [31:0] sample
   input  wire logic [mma_pkg::CH_W-1:0]      req_tuser,   // [2:0] channel
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [3*mma_pkg::SAMPLE_W-1:0] rsp_tdata,  // [31:0] average,
                                                           // [63:32] lowest_average,
                                                           // [95:64] highest_average
   output      logic [mma_pkg::CH_W:0]        rsp_tuser    // [2:0] channel_out,
                                                           // [3] window_full
);

   mma_pkg::item_type                   item;
   logic                                item_valid;
   logic                                item_pop;
   logic [mma_pkg::CH_W-1:0]            channel_out;
   logic signed [mma_pkg::SAMPLE_W-1:0] average;
   logic signed [mma_pkg::SAMPLE_W-1:0] lowest_average;
   logic signed [mma_pkg::SAMPLE_W-1:0] highest_average;
   logic                                window_full;

   mma_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_channel (req_tuser),
      .req_sample  (req_tdata),
      .item        (item),
      .item_valid  (item_valid),
      .item_pop    (item_pop)
   );

   mma_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item            (item),
      .item_valid      (item_valid),
      .item_pop        (item_pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .channel_out     (channel_out),
      .average         (average),
      .lowest_average  (lowest_average),
      .highest_average (highest_average),
      .window_full     (window_full)
   );

   assign rsp_tdata = {highest_average, lowest_average, average};
   assign rsp_tuser = {window_full, channel_out};

   // the back end only pops a queued item
   `ASSERT_IMPLY(a_pop_has_item, item_pop, item_valid, "pop from empty item queue")

   // min above max only while a channel has no average yet
   `ASSERT_IMPLY(a_untouched_result, rsp_tvalid && (lowest_average > highest_average),
                 (average == '0) && !window_full, "inverted min/max on a tracked channel")

   // a tracked average lies inside its own min/max
   `ASSERT_IMPLY(a_avg_in_range, rsp_tvalid && (lowest_average <= highest_average),
                 (lowest_average <= average) && (average <= highest_average),
                 "average outside its min/max")

   // the sender sees back-pressure only while work is queued
   `ASSERT_ALWAYS(a_ready_when_empty, item_valid || req_tready, "stalled with empty queue")

endmodule

`default_nettype wire
